/* sv/bht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bht_pkg
// Shared types, constants and the counter update rule of the button hold
// tracker.
// ----------------------------------------------------------------------------
package bht_pkg;

	localparam int BUTTON_COUNT = 7;
	localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
	localparam int PIN_BITS     = 6;
	localparam int QUERY_W      = 3;
	localparam int MASK_W       = 7;
	localparam int CNT_W        = 8;
	localparam int CMP_W        = (BTN_IDX_W > QUERY_W) ? BTN_IDX_W : QUERY_W;
	localparam int IDX_LEFT     = 0;
	localparam int IDX_RIGHT    = 2;
	localparam int CFG_IDX_W    = 1;

	localparam logic [CNT_W-1:0] MARK_RELEASED = 8'hFF;
	localparam logic [CNT_W-1:0] COUNT_MAX     = 8'd254;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TARGET   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD = 1'd1;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [BTN_IDX_W-1:0] btn_idx_t;
	typedef logic [MASK_W-1:0]    mask_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CALC,
		S_REM,
		S_FINISH
	} state_t;

	// Counter step for one physical button on one tick.
	function automatic cnt_t next_count(input cnt_t c, input logic down);
		cnt_t r;
		if (down) begin
			if (c == MARK_RELEASED) r = '0;
			else if (c >= COUNT_MAX) r = COUNT_MAX;
			else r = c + cnt_t'(1);
		end else begin
			if (c == '0 || c == MARK_RELEASED) r = '0;
			else r = MARK_RELEASED;
		end
		return r;
	endfunction

endpackage

/* sv/bht_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bht_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bht_ram #(
	parameter int DEPTH  = 7,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/bht_rem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bht_rem
// Restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bht_rem (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  bht_pkg::cnt_t dividend,
	input  bht_pkg::cnt_t divisor,
	output logic        busy,
	output bht_pkg::cnt_t remainder
);
	import bht_pkg::*;

	localparam int STEP_W = $clog2(CNT_W + 1);

	logic [STEP_W-1:0] steps_q;
	cnt_t              dvd_q;
	cnt_t              rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[CNT_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q <= '0;
		end else if (start) begin
			steps_q <= STEP_W'(CNT_W);
		end else if (steps_q != '0) begin
			steps_q <= steps_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (steps_q != '0) begin
			dvd_q <= {dvd_q[CNT_W-2:0], 1'b0};
			// the remainder stays below the divisor, so the low bits suffice
			rem_q <= (trial >= {1'b0, divisor}) ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign busy      = (steps_q != '0);
	assign remainder = rem_q;

endmodule

/* sv/button_hold_tracker_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_hold_tracker_core
// Per-button hold counters kept in a small RAM, updated once per scan beat.
// ----------------------------------------------------------------------------
// Each button takes a RAM read, a write-back, an 8-step remainder for the
//   auto-repeat test and a fold into the masks; the finish state then
//   loads the output register.
// Beats: a new beat is accepted only in the idle state, once the last one
//   is through; it is accepted while the previous result still waits in
//   the output register.
// Reset: arst_n clears the control state, the entry valid bits (all counters
//   read as idle), hold_target to 0 and repeat_period to 1.
// ----------------------------------------------------------------------------
module button_hold_tracker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [bht_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bht_pkg::CNT_W-1:0]     cfg_data,
	// input beats
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [bht_pkg::PIN_BITS-1:0]  pin_levels,
	input  logic [bht_pkg::QUERY_W-1:0]   query_button,
	// result beats
	output logic                          out_valid,
	input  logic                          out_ready,
	output bht_pkg::mask_t                pressed_mask,
	output bht_pkg::mask_t                released_mask,
	output bht_pkg::mask_t                held_mask,
	output bht_pkg::mask_t                repeat_mask,
	output bht_pkg::cnt_t                 hold_time
);
	import bht_pkg::*;

	// configuration registers
	cnt_t hold_target_q;
	cnt_t repeat_period_q;

	// sequencer
	state_t   state_q, state_d;
	btn_idx_t btn_q;
	logic     last_btn;

	// captured input beat
	logic [PIN_BITS-1:0] levels_q;
	logic [QUERY_W-1:0]  query_q;

	// counter storage: the RAM plus one valid bit per entry so that
	// unwritten entries read as idle after reset
	logic [BUTTON_COUNT-1:0] valid_q;
	cnt_t                    rd_data;
	cnt_t                    cur_cnt;
	cnt_t                    nxt_cnt;
	cnt_t                    nxt_cnt_q;
	logic                    down;

	// combo bookkeeping
	logic left_one_q;
	logic right_one_q;

	// remainder unit
	cnt_t rem;
	logic rem_busy;

	// accumulators and output register
	mask_t pm_acc_q, rm_acc_q, hm_acc_q, am_acc_q;
	cnt_t  ht_acc_q;
	mask_t bit_sel;
	logic  rep_bit;
	logic  held_bit;

	logic out_valid_q;
	mask_t pm_q, rm_q, hm_q, am_q;
	cnt_t  ht_q;

	// control strobes
	logic accept;
	logic rd_en;
	logic wr_en;
	logic rem_start;
	logic acc_en;
	logic out_load;

	// ------------------------------------------------------------------------
	// Configuration: to be written by the user only while idle, so no hazard with the datapath; not enforced here.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_target_q   <= '0;
			repeat_period_q <= cnt_t'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOLD_TARGET:   hold_target_q   <= cfg_data;
				REG_REPEAT_PERIOD: repeat_period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer: for each button, read the counter, compute and write back
	// the new count, then run the remainder and fold the flags into the
	// masks. The virtual combo button is last, after left and right.
	// ------------------------------------------------------------------------
	assign accept   = in_valid && in_ready;
	assign last_btn = (btn_q == btn_idx_t'(BUTTON_COUNT - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_READ;
			S_READ:   state_d = S_CALC;
			S_CALC:   state_d = S_REM;
			S_REM:    if (!rem_busy) state_d = last_btn ? S_FINISH : S_READ;
			S_FINISH: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		wr_en     = 1'b0;
		rem_start = 1'b0;
		acc_en    = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ready = 1'b1;
			S_READ:   rd_en = 1'b1;
			S_CALC: begin
				wr_en     = 1'b1;
				rem_start = 1'b1;
			end
			S_REM:    acc_en = !rem_busy;
			S_FINISH: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			btn_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				btn_q <= '0;
			end else if (acc_en && !last_btn) begin
				btn_q <= btn_q + btn_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= pin_levels;
			query_q  <= query_button;
		end
	end

	// ------------------------------------------------------------------------
	// Counter RAM. Each entry is read and written once per beat, and the
	// write of one entry lands before any later read of it, so no
	// forwarding is needed.
	// ------------------------------------------------------------------------
	bht_ram #(
		.DEPTH (BUTTON_COUNT),
		.WIDTH (CNT_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (btn_q),
		.wr_data (nxt_cnt),
		.rd_en   (rd_en),
		.rd_addr (btn_q),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[btn_q] <= 1'b1;
		end
	end

	assign cur_cnt = valid_q[btn_q] ? rd_data : '0;

	// buttons past the pin field read as not pressed
	assign down = (32'(btn_q) < 32'(PIN_BITS)) &&
		(((levels_q >> btn_q) & PIN_BITS'(1)) == '0);

	// combo reads 1 only when left and right both show their first tick
	always_comb begin
		if (last_btn) begin
			nxt_cnt = (left_one_q && right_one_q) ? cnt_t'(1) : '0;
		end else begin
			nxt_cnt = next_count(cur_cnt, down);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			nxt_cnt_q <= nxt_cnt;
		end
	end

	// ------------------------------------------------------------------------
	// Auto-repeat remainder of the new count by the period.
	// ------------------------------------------------------------------------
	bht_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (nxt_cnt),
		.divisor   (repeat_period_q),
		.busy      (rem_busy),
		.remainder (rem)
	);

	// ------------------------------------------------------------------------
	// Flag accumulation.
	// ------------------------------------------------------------------------
	// buttons beyond the mask width shift out and leave no bit
	assign bit_sel  = mask_t'(1) << btn_q;
	assign held_bit = ({1'b0, nxt_cnt_q} == ({1'b0, hold_target_q} + 9'd1));

	always_comb begin
		if (nxt_cnt_q == MARK_RELEASED) rep_bit = 1'b0;
		else if (repeat_period_q <= cnt_t'(1)) rep_bit = (nxt_cnt_q != '0);
		else rep_bit = (rem == cnt_t'(1));
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pm_acc_q    <= '0;
			rm_acc_q    <= '0;
			hm_acc_q    <= '0;
			am_acc_q    <= '0;
			ht_acc_q    <= '0;
			left_one_q  <= 1'b0;
			right_one_q <= 1'b0;
		end else if (acc_en) begin
			if (nxt_cnt_q == cnt_t'(1))    pm_acc_q <= pm_acc_q | bit_sel;
			if (nxt_cnt_q == MARK_RELEASED) rm_acc_q <= rm_acc_q | bit_sel;
			if (held_bit)                  hm_acc_q <= hm_acc_q | bit_sel;
			if (rep_bit)                   am_acc_q <= am_acc_q | bit_sel;
			// report the queried button; the marker reads as zero
			if (CMP_W'(query_q) == CMP_W'(btn_q) && nxt_cnt_q != MARK_RELEASED) begin
				ht_acc_q <= nxt_cnt_q;
			end
			if (btn_q == btn_idx_t'(IDX_LEFT)) left_one_q <= (nxt_cnt_q == cnt_t'(1));
			if (btn_q == btn_idx_t'(IDX_RIGHT)) right_one_q <= (nxt_cnt_q == cnt_t'(1));
		end
	end

	// ------------------------------------------------------------------------
	// Output register: hold the result beat until it is taken.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pm_q <= pm_acc_q;
			rm_q <= rm_acc_q;
			hm_q <= hm_acc_q;
			am_q <= am_acc_q;
			ht_q <= ht_acc_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pressed_mask  = pm_q;
	assign released_mask = rm_q;
	assign held_mask     = hm_q;
	assign repeat_mask   = am_q;
	assign hold_time     = ht_q;

endmodule
